### src/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain package
// Shared widths, codes, stage tags and the logarithmic curve table.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int TIME_BITS    = 24;
  localparam int CURVE_POINTS = 1024;
  localparam int CP_BITS      = $clog2(CURVE_POINTS);
  localparam int Q_BITS       = 15;
  localparam int E_BITS       = TIME_BITS + 2;
  localparam int G_BITS       = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int SETTLE       = 3;
  // input register, window stage, divider stages, table, multiply, output
  localparam int LATENCY      = Q_BITS + 5;

  localparam logic [16:0] UNITY = 17'd32768;

  typedef enum logic [2:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CURVE_MODE = 3'd0,
    CFG_ATTACK     = 3'd1,
    CFG_DECAY      = 3'd2,
    CFG_SUSTAIN    = 3'd3,
    CFG_HOLD       = 3'd4,
    CFG_RELEASE    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic   valid;
    phase_t phase;
  } tag_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] attack;
    logic [TIME_BITS-1:0] decay;
    logic [TIME_BITS-1:0] release_len;
    logic [E_BITS-1:0]    e2;
    logic [E_BITS-1:0]    e3;
    logic [E_BITS-1:0]    e4;
  } win_cfg_t;

  typedef logic [G_BITS-1:0] curve_rom_t [CURVE_POINTS];

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // f(u) = 2*log2(1+u)/(1+u), Q1.15, evaluated at elaboration
  function automatic curve_rom_t build_curve();
    curve_rom_t      rom;
    longint unsigned x;
    longint unsigned y;
    longint unsigned l;
    longint unsigned q;
    longint unsigned v;
    for (int k = 0; k < CURVE_POINTS; k++) begin
      x = longint'(CURVE_POINTS + k) << (30 - CP_BITS);
      y = x;
      l = 64'd0;
      for (int i = 1; i <= 30; i++) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          l = l | (64'd1 << (30 - i));
        end
      end
      q = udiv64(l * 64'd65536 * 64'(CURVE_POINTS), 64'(CURVE_POINTS + k));
      v = (q + (64'd1 << 29)) >> 30;
      if (v > 64'd32768) v = 64'd32768;
      rom[k] = v[G_BITS-1:0];
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

endpackage

### src/adsr_phase.sv
// ----------------------------------------------------------------------------
// ADSR phase window stage
// Places the tick count in its window and forms offset and phase length.
// ----------------------------------------------------------------------------
module adsr_phase (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [adsr_pkg::TIME_BITS-1:0] in_ticks,
  input  adsr_pkg::win_cfg_t             win,
  output adsr_pkg::tag_t                 tag_o,
  output logic [adsr_pkg::TIME_BITS-1:0] off_o,
  output logic [adsr_pkg::TIME_BITS-1:0] len_o
);

  adsr_pkg::tag_t                 tag_r, tag_nxt;
  logic [adsr_pkg::TIME_BITS-1:0] off_r, off_nxt;
  logic [adsr_pkg::TIME_BITS-1:0] len_r, len_nxt;
  logic [adsr_pkg::E_BITS-1:0]    t_e;
  logic [adsr_pkg::E_BITS-1:0]    diff;

  always_comb begin
    t_e           = {2'b00, in_ticks};
    diff          = '0;
    tag_nxt.valid = in_valid;
    priority if (t_e < {2'b00, win.attack}) begin
      tag_nxt.phase = adsr_pkg::PH_ATTACK;
      off_nxt       = in_ticks;
      len_nxt       = win.attack;
    end else if (t_e < win.e2) begin
      diff          = t_e - {2'b00, win.attack};
      tag_nxt.phase = adsr_pkg::PH_DECAY;
      off_nxt       = diff[adsr_pkg::TIME_BITS-1:0];
      len_nxt       = win.decay;
    end else if (t_e < win.e3) begin
      tag_nxt.phase = adsr_pkg::PH_SUSTAIN;
      off_nxt       = '0;
      len_nxt       = adsr_pkg::TIME_BITS'(1);
    end else if (t_e < win.e4) begin
      diff          = t_e - win.e3;
      tag_nxt.phase = adsr_pkg::PH_RELEASE;
      off_nxt       = diff[adsr_pkg::TIME_BITS-1:0];
      len_nxt       = win.release_len;
    end else begin
      tag_nxt.phase = adsr_pkg::PH_DONE;
      off_nxt       = '0;
      len_nxt       = adsr_pkg::TIME_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= tag_nxt.valid;
    end
    tag_r.phase <= tag_nxt.phase;
    off_r       <= off_nxt;
    len_r       <= len_nxt;
  end

  assign tag_o = tag_r;
  assign off_o = off_r;
  assign len_o = len_r;

endmodule

### src/adsr_div.sv
// ----------------------------------------------------------------------------
// ADSR fraction divider
// Pipelined restoring division, one quotient bit per stage: off*2^15/len.
// ----------------------------------------------------------------------------
module adsr_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  adsr_pkg::tag_t                 tag_i,
  input  logic [adsr_pkg::TIME_BITS-1:0] off_i,
  input  logic [adsr_pkg::TIME_BITS-1:0] len_i,
  output adsr_pkg::tag_t                 tag_o,
  output logic [adsr_pkg::Q_BITS-1:0]    quo_o
);

  localparam int TB = adsr_pkg::TIME_BITS;
  localparam int NS = adsr_pkg::Q_BITS;

  adsr_pkg::tag_t              tag_r [NS];
  logic [TB-1:0]               rem_r [NS];
  logic [TB-1:0]               len_r [NS];
  logic [adsr_pkg::Q_BITS-1:0] quo_r [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    adsr_pkg::tag_t              tag_in;
    logic [TB-1:0]               rem_in;
    logic [TB-1:0]               len_in;
    logic [adsr_pkg::Q_BITS-1:0] quo_in;
    logic [TB:0]                 rem2;
    logic [TB:0]                 rem_sub;
    logic                        ge;
    logic [TB-1:0]               rem_nxt;
    logic [adsr_pkg::Q_BITS-1:0] quo_nxt;

    if (g == 0) begin : g_first
      assign tag_in = tag_i;
      assign rem_in = off_i;
      assign len_in = len_i;
      assign quo_in = '0;
    end else begin : g_next
      assign tag_in = tag_r[g-1];
      assign rem_in = rem_r[g-1];
      assign len_in = len_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    always_comb begin
      rem2    = {rem_in, 1'b0};
      ge      = rem2 >= {1'b0, len_in};
      rem_sub = rem2 - {1'b0, len_in};
      rem_nxt = ge ? rem_sub[TB-1:0] : rem2[TB-1:0];
      quo_nxt = {quo_in[adsr_pkg::Q_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[g].valid <= 1'b0;
      end else begin
        tag_r[g].valid <= tag_in.valid;
      end
      tag_r[g].phase <= tag_in.phase;
      rem_r[g]       <= rem_nxt;
      len_r[g]       <= len_in;
      quo_r[g]       <= quo_nxt;
    end
  end

  assign tag_o = tag_r[NS-1];
  assign quo_o = quo_r[NS-1];

endmodule

### src/adsr_gain.sv
// ----------------------------------------------------------------------------
// ADSR gain shaper
// Curve lookup, level scaling and the final per-phase gain select.
// ----------------------------------------------------------------------------
module adsr_gain (
  input  logic                         clk,
  input  logic                         rst_n,
  input  adsr_pkg::tag_t               tag_i,
  input  logic [adsr_pkg::Q_BITS-1:0]  quo_i,
  input  logic                         curve_mode,
  input  logic [adsr_pkg::G_BITS-1:0]  sus_lvl,
  output logic                         out_valid,
  output logic [adsr_pkg::G_BITS-1:0]  out_gain,
  output logic [2:0]                   out_phase
);

  localparam int GB = adsr_pkg::G_BITS;

  adsr_pkg::tag_t tag_a_r, tag_b_r, tag_c_r;
  logic [GB-1:0]  shp_a_r, shp_a_nxt;
  logic [GB-1:0]  shp_b_r;
  logic [GB-1:0]  scl_b_r, scl_b_nxt;
  logic [GB-1:0]  gain_r, gain_nxt;
  logic [16:0]    coef;
  logic [32:0]    prod;
  logic [16:0]    gdiff;

  // curve mode indexes the table with the top quotient bits, linear mode passes the quotient
  always_comb begin
    if (curve_mode) begin
      shp_a_nxt = adsr_pkg::CURVE_ROM[quo_i[adsr_pkg::Q_BITS-1 -: adsr_pkg::CP_BITS]];
    end else begin
      shp_a_nxt = {1'b0, quo_i};
    end
  end

  always_comb begin
    coef      = (tag_a_r.phase == adsr_pkg::PH_DECAY) ?
                (adsr_pkg::UNITY - {1'b0, sus_lvl}) : {1'b0, sus_lvl};
    prod      = {16'd0, coef} * {17'd0, shp_a_r};
    scl_b_nxt = prod[GB+14:15];
  end

  always_comb begin
    gdiff = '0;
    unique case (tag_b_r.phase)
      adsr_pkg::PH_ATTACK:  gain_nxt = shp_b_r;
      adsr_pkg::PH_DECAY: begin
        gdiff    = adsr_pkg::UNITY - {1'b0, scl_b_r};
        gain_nxt = gdiff[GB-1:0];
      end
      adsr_pkg::PH_SUSTAIN: gain_nxt = sus_lvl;
      adsr_pkg::PH_RELEASE: gain_nxt = sus_lvl - scl_b_r;
      default:              gain_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r.valid <= 1'b0;
      tag_b_r.valid <= 1'b0;
      tag_c_r.valid <= 1'b0;
    end else begin
      tag_a_r.valid <= tag_i.valid;
      tag_b_r.valid <= tag_a_r.valid;
      tag_c_r.valid <= tag_b_r.valid;
    end
    tag_a_r.phase <= tag_i.phase;
    tag_b_r.phase <= tag_a_r.phase;
    tag_c_r.phase <= tag_b_r.phase;
    shp_a_r       <= shp_a_nxt;
    shp_b_r       <= shp_a_r;
    scl_b_r       <= scl_b_nxt;
    gain_r        <= gain_nxt;
  end

  assign out_valid = tag_c_r.valid;
  assign out_gain  = gain_r;
  assign out_phase = tag_c_r.phase;

endmodule

### src/adsr_envelope_gain_top.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain generator, top level
// Maps ticks since note start to an envelope phase and a Q1.15 gain.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_elapsed_ticks and raise start; the beat is taken at a
//   rising edge where start is high and busy is low. One beat per cycle may
//   be issued back to back while busy is low.
//   Output: out_valid strobes for one cycle with out_gain and out_phase,
//   after the input register, window stage, 15 divider stages, curve
//   table, level multiply and output register. Results leave in issue
//   order. The receiver cannot stall and the pipeline never holds.
//   Throughput: one item per cycle while busy is low; the fraction divider
//   is fully pipelined with one quotient bit per stage.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. The
//   user must write only while the pipeline is empty; the block itself
//   does not enforce it. After a write, busy stays high while the phase
//   window edges are re-summed.
//   Reset: rst_n low clears all valid bits, loads the register defaults and
//   holds busy high until the settle counter runs down after release.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [adsr_pkg::TIME_BITS-1:0]       in_elapsed_ticks,
  output logic                                 out_valid,
  output logic [adsr_pkg::G_BITS-1:0]          out_gain,
  output logic [2:0]                           out_phase,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [adsr_pkg::TIME_BITS-1:0]       cfg_data
);

  localparam int TB = adsr_pkg::TIME_BITS;
  localparam int EB = adsr_pkg::E_BITS;

  // configuration registers
  logic          mode_r;
  logic [TB-1:0] attack_r, decay_r, hold_r, release_r;
  logic [15:0]   sustain_r;
  logic [EB-1:0] e2_r, e3_r, e4_r;
  logic [1:0]    settle_r, settle_nxt;
  logic          cfg_wr;
  logic [15:0]   sus_lvl;

  // input register
  logic          in_v_r;
  logic [TB-1:0] in_t_r;
  logic          accept;

  adsr_pkg::win_cfg_t         win;
  adsr_pkg::tag_t             ph_tag, dv_tag;
  logic [TB-1:0]              ph_off, ph_len;
  logic [adsr_pkg::Q_BITS-1:0] dv_quo;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = (settle_r != 2'd0);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b1;
      attack_r  <= TB'(4800);
      decay_r   <= TB'(4800);
      sustain_r <= 16'd16384;
      hold_r    <= TB'(96000);
      release_r <= TB'(4800);
    end else if (cfg_wr) begin
      unique case (adsr_pkg::cfg_idx_t'(cfg_index))
        adsr_pkg::CFG_CURVE_MODE: mode_r    <= cfg_data[0];
        adsr_pkg::CFG_ATTACK:     attack_r  <= cfg_data;
        adsr_pkg::CFG_DECAY:      decay_r   <= cfg_data;
        adsr_pkg::CFG_SUSTAIN:    sustain_r <= cfg_data[15:0];
        adsr_pkg::CFG_HOLD:       hold_r    <= cfg_data;
        adsr_pkg::CFG_RELEASE:    release_r <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // hold busy while the window edges ripple through the three sums
  always_comb begin
    if (cfg_wr) begin
      settle_nxt = 2'(adsr_pkg::SETTLE);
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 2'(adsr_pkg::SETTLE);
      in_v_r   <= 1'b0;
    end else begin
      settle_r <= settle_nxt;
      in_v_r   <= accept;
    end
  end

  always_ff @(posedge clk) begin
    e2_r   <= {2'b00, attack_r} + {2'b00, decay_r};
    e3_r   <= e2_r + {2'b00, hold_r};
    e4_r   <= e3_r + {2'b00, release_r};
    in_t_r <= in_elapsed_ticks;
  end

  // sustain above unity saturates
  assign sus_lvl = ({1'b0, sustain_r} > adsr_pkg::UNITY) ? 16'd32768 : sustain_r;

  always_comb begin
    win.attack      = attack_r;
    win.decay       = decay_r;
    win.release_len = release_r;
    win.e2          = e2_r;
    win.e3          = e3_r;
    win.e4          = e4_r;
  end

  adsr_phase u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_v_r),
    .in_ticks (in_t_r),
    .win      (win),
    .tag_o    (ph_tag),
    .off_o    (ph_off),
    .len_o    (ph_len)
  );

  adsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (ph_tag),
    .off_i (ph_off),
    .len_i (ph_len),
    .tag_o (dv_tag),
    .quo_o (dv_quo)
  );

  adsr_gain u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag_i      (dv_tag),
    .quo_i      (dv_quo),
    .curve_mode (mode_r),
    .sus_lvl    (sus_lvl),
    .out_valid  (out_valid),
    .out_gain   (out_gain),
    .out_phase  (out_phase)
  );

  // every accepted beat yields exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(adsr_pkg::LATENCY) out_valid)
    else $error("result missing after pipeline latency");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == adsr_pkg::PH_DONE) |-> (out_gain == 16'd0))
    else $error("finished phase with nonzero gain");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_gain} <= adsr_pkg::UNITY))
    else $error("gain above unity");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("input not blocked after configuration write");

endmodule

### tb/adsr_gain_checker.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain checker
// Tracks register writes, predicts the phase and gain of every accepted beat
// and compares each output strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module adsr_gain_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [adsr_pkg::TIME_BITS-1:0]       in_elapsed_ticks,
  input  logic                                 out_valid,
  input  logic [adsr_pkg::G_BITS-1:0]          out_gain,
  input  logic [2:0]                           out_phase,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [adsr_pkg::TIME_BITS-1:0]       cfg_data,
  output int                                   mismatches,
  output int                                   pending
);

  typedef struct {
    logic [adsr_pkg::G_BITS-1:0] gain;
    adsr_pkg::phase_t            phase;
  } env_point_t;

  logic [adsr_pkg::G_BITS-1:0]    shape_table [adsr_pkg::CURVE_POINTS];
  logic                           log_mode;
  logic [adsr_pkg::TIME_BITS-1:0] atk_len, dec_len, hold_len, rel_len;
  logic [15:0]                    sus_lvl;
  env_point_t                     env_queue [$];

  initial begin
    longint unsigned x, y, l, q, v;
    mismatches = 0;
    for (int k = 0; k < adsr_pkg::CURVE_POINTS; k++) begin
      x = (longint'(adsr_pkg::CURVE_POINTS + k) << 30) / adsr_pkg::CURVE_POINTS;
      y = x;
      l = 0;
      for (int i = 1; i <= 30; i++) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          l = l | (64'd1 << (30 - i));
        end
      end
      q = (l * 65536 * adsr_pkg::CURVE_POINTS) / (adsr_pkg::CURVE_POINTS + k);
      v = (q + (64'd1 << 29)) >> 30;
      if (v > 32768) v = 32768;
      shape_table[k] = v[adsr_pkg::G_BITS-1:0];
    end
  end

  function automatic longint unsigned shape_of(longint unsigned off, longint unsigned len);
    longint unsigned k;
    if (log_mode) begin
      k = (off * adsr_pkg::CURVE_POINTS) / len;
      if (k >= adsr_pkg::CURVE_POINTS) k = adsr_pkg::CURVE_POINTS - 1;
      return shape_table[k];
    end
    return (off * 32768) / len;
  endfunction

  function automatic env_point_t envelope_at(logic [adsr_pkg::TIME_BITS-1:0] t);
    env_point_t      p;
    longint unsigned s, e1, e2, e3, e4, g;
    s  = (sus_lvl > 32768) ? 32768 : sus_lvl;
    e1 = atk_len;
    e2 = e1 + dec_len;
    e3 = e2 + hold_len;
    e4 = e3 + rel_len;
    if (t < e1) begin
      p.phase = adsr_pkg::PH_ATTACK;
      g = shape_of(t, atk_len);
    end else if (t < e2) begin
      p.phase = adsr_pkg::PH_DECAY;
      g = 32768 - (((32768 - s) * shape_of(t - e1, dec_len)) >> 15);
    end else if (t < e3) begin
      p.phase = adsr_pkg::PH_SUSTAIN;
      g = s;
    end else if (t < e4) begin
      p.phase = adsr_pkg::PH_RELEASE;
      g = s - ((s * shape_of(t - e3, rel_len)) >> 15);
    end else begin
      p.phase = adsr_pkg::PH_DONE;
      g = 0;
    end
    p.gain = g[adsr_pkg::G_BITS-1:0];
    return p;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    env_point_t want;
    if (!rst_n) begin
      log_mode = 1'b1;
      atk_len  = 4800;
      dec_len  = 4800;
      sus_lvl  = 16384;
      hold_len = 96000;
      rel_len  = 4800;
      env_queue.delete();
    end else begin
      if (out_valid) begin
        if (env_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected beat gain %0d phase %0d", out_gain, out_phase));
        end else begin
          want = env_queue.pop_front();
          if (out_gain !== want.gain)
            report_mismatch($sformatf("gain %0d, want %0d", out_gain, want.gain));
          if (out_phase !== want.phase)
            report_mismatch($sformatf("phase %0d, want %0d", out_phase, want.phase));
        end
      end
      if (start && !busy) env_queue.push_back(envelope_at(in_elapsed_ticks));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          adsr_pkg::CFG_CURVE_MODE: log_mode = cfg_data[0];
          adsr_pkg::CFG_ATTACK:     atk_len  = cfg_data;
          adsr_pkg::CFG_DECAY:      dec_len  = cfg_data;
          adsr_pkg::CFG_SUSTAIN:    sus_lvl  = cfg_data[15:0];
          adsr_pkg::CFG_HOLD:       hold_len = cfg_data;
          adsr_pkg::CFG_RELEASE:    rel_len  = cfg_data;
          default: ;
        endcase
      end
    end
    pending = env_queue.size();
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain testbench
// Drives tick counts through several register settings (linear and curve
// mode, zero and maximum phase lengths, sustain above unity) and lets the
// checker score every output beat against its own envelope prediction.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [adsr_pkg::TIME_BITS-1:0] ticks_t;

  localparam int NUM_SETTINGS = 12;
  localparam int BEATS_PER    = 85;
  localparam int CYCLE_LIMIT  = 300000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  ticks_t                            in_elapsed_ticks = '0;
  logic                              out_valid;
  logic [adsr_pkg::G_BITS-1:0]       out_gain;
  logic [2:0]                        out_phase;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [adsr_pkg::CFG_IDX_BITS-1:0] cfg_index = adsr_pkg::CFG_CURVE_MODE;
  ticks_t                            cfg_data = '0;
  int                                mismatches;
  int                                pending;
  int                                cycles = 0;
  int                                beats_sent = 0;

  // window lengths as last written, used only to aim the stimulus
  longint unsigned atk_w = 4800, dec_w = 4800, hold_w = 96000, rel_w = 4800;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  adsr_envelope_gain_top u_top (.*);

  adsr_gain_checker u_chk (.*);

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("adsr_envelope_gain_top test failed");
      $finish;
    end
  end

  // Present one tick count and hold start until the edge that takes it.
  // Start is left high so back-to-back beats never drop it.
  task automatic send_ticks(ticks_t t);
    start            <= 1'b1;
    in_elapsed_ticks <= t;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // Drop start for one cycle after about 22 of a hundred beats, which leaves
  // the input idle while start is low.
  task automatic maybe_gap(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain the pipeline before touching registers.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Leave cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(adsr_pkg::cfg_idx_t idx, ticks_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      adsr_pkg::CFG_ATTACK:  atk_w  = val;
      adsr_pkg::CFG_DECAY:   dec_w  = val;
      adsr_pkg::CFG_HOLD:    hold_w = val;
      adsr_pkg::CFG_RELEASE: rel_w  = val;
      default: ;
    endcase
  endtask

  function automatic ticks_t pick_len(int setting);
    if (setting == 2) return '0;
    if (setting == 3) return '1;
    if ($urandom_range(0, 5) == 0) return '0;
    if ($urandom_range(0, 9) == 0) return ticks_t'($urandom_range(1, 4));
    return ticks_t'($urandom_range(1, 3000));
  endfunction

  function automatic ticks_t pick_sustain(int setting);
    case (setting % 4)
      0: return 24'd0;
      1: return 24'd32768;
      2: return '1;
      default: return ticks_t'($urandom_range(0, 32768));
    endcase
  endfunction

  // Mostly aim inside the envelope windows, sometimes anywhere at all.
  function automatic ticks_t pick_ticks();
    longint unsigned top_t;
    top_t = atk_w + dec_w + hold_w + rel_w + 8;
    if (top_t > 24'hFFFFFF || $urandom_range(0, 99) < 15) return ticks_t'($urandom);
    return ticks_t'($urandom_range(0, int'(top_t)));
  endfunction

  initial begin
    longint unsigned e;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes and every window edge
    e = 0;
    send_ticks('0);
    send_ticks('1);
    for (int w = 0; w < 4; w++) begin
      e += (w == 0) ? atk_w : (w == 1) ? dec_w : (w == 2) ? hold_w : rel_w;
      send_ticks(ticks_t'(e - 1));
      send_ticks(ticks_t'(e));
      send_ticks(ticks_t'(e + 1));
    end
    send_ticks(ticks_t'(atk_w / 2));
    send_ticks(ticks_t'(atk_w + dec_w / 2));

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_idle();
      write_reg(adsr_pkg::CFG_CURVE_MODE, (s == 0) ? 24'hFFFFFE : 24'(s % 2));
      write_reg(adsr_pkg::CFG_ATTACK, pick_len(s));
      write_reg(adsr_pkg::CFG_DECAY, pick_len(s));
      write_reg(adsr_pkg::CFG_SUSTAIN, pick_sustain(s));
      write_reg(adsr_pkg::CFG_HOLD, pick_len(s));
      write_reg(adsr_pkg::CFG_RELEASE, pick_len(s));
      cfg_valid <= 1'b0;
      for (int n = 0; n < BEATS_PER; n++) begin
        send_ticks(pick_ticks());
        // setting 5 runs without any gaps
        maybe_gap(s == 5);
      end
    end

    wait_idle();
    repeat (adsr_pkg::LATENCY + 5) @(posedge clk);
    $display("Covered %0d beats over %0d register settings in both curve modes,",
             beats_sent, NUM_SETTINGS + 1);
    $display("including empty and maximum windows and sustain above unity.");
    if (mismatches == 0 && pending == 0) begin
      $display("adsr_envelope_gain_top test passed");
    end else begin
      $display("adsr_envelope_gain_top test failed");
    end
    $finish;
  end

endmodule
